@@ rtl/sacd_pkg.sv @@
package sacd_pkg;

	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 4;
	localparam int TAG_BITS = 22;

	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int WAY_BITS = $clog2(NUM_WAYS);
	// one instruction half and one data half
	localparam int ROW_BITS = SET_BITS + 1;
	localparam int ROWS = 2 * NUM_SETS;

	localparam int MODE_BITS = 2;
	localparam logic [MODE_BITS-1:0] MODE_IREAD = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_DREAD = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_DWRITE = 2'd2;

	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 32;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPL_MODE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED = 1'b1;

	localparam logic REPL_LRU = 1'b0;
	localparam logic REPL_RANDOM = 1'b1;

	localparam logic [31:0] LCG_MUL = 32'd214013;
	localparam logic [31:0] LCG_INC = 32'd2531011;
	localparam logic [31:0] SEED_RESET = 32'd1;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic [SET_BITS-1:0] set_index;
		logic [TAG_BITS-1:0] line_tag;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [WAY_BITS-1:0] way;
		logic victim_valid;
		logic victim_dirty;
		logic [TAG_BITS-1:0] victim_tag;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic dirty;
		logic [WAY_BITS-1:0] age;
		logic [TAG_BITS-1:0] tag;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

endpackage

@@ rtl/sacd_ctrl.sv @@
module sacd_ctrl import sacd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic rsp_valid_q;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// result register must be free, or freed this cycle, before the row is written
	assign cmd.accept = req_valid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_EVAL) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/sacd_dpath.sv @@
module sacd_dpath import sacd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output rsp_t rsp
);

	row_t mem [ROWS];

	logic repl_mode_q;
	logic [31:0] lcg_q;
	logic [31:0] lcg_next;
	logic [ROWS-1:0] row_init_q;
	logic init_rd_q;
	req_t req_q;
	row_t row_q;
	rsp_t rsp_q;

	logic [ROW_BITS-1:0] in_row;
	logic [ROW_BITS-1:0] cur_idx;
	row_t cur_row;
	row_t new_row;
	logic lru;
	logic hit;
	logic [WAY_BITS-1:0] hit_way;
	logic inv_found;
	logic [WAY_BITS-1:0] inv_way;
	logic [WAY_BITS-1:0] old_way;
	logic [WAY_BITS-1:0] way_sel;
	logic evict;
	logic rand_take;
	logic [WAY_BITS-1:0] old_age;

	assign in_row = {req.mode != MODE_IREAD, req.set_index};
	assign cur_idx = {req_q.mode != MODE_IREAD, req_q.set_index};
	// a row never written reads as all lines invalid, clean and age zero
	assign cur_row = init_rd_q ? row_q : '0;
	assign lru = (repl_mode_q == REPL_LRU);
	assign lcg_next = 32'(lcg_q * LCG_MUL + LCG_INC);

	// lowest-numbered way wins in each search
	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		inv_found = 1'b0;
		inv_way = '0;
		old_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (cur_row[w].valid && (cur_row[w].tag == req_q.line_tag)) begin
				hit = 1'b1;
				hit_way = WAY_BITS'(w);
			end
			if (!cur_row[w].valid) begin
				inv_found = 1'b1;
				inv_way = WAY_BITS'(w);
			end
			if (cur_row[w].age == WAY_BITS'(NUM_WAYS - 1)) begin
				old_way = WAY_BITS'(w);
			end
		end
	end

	always_comb begin
		evict = !hit && !inv_found;
		rand_take = evict && !lru;
		if (hit) begin
			way_sel = hit_way;
		end else if (inv_found) begin
			way_sel = inv_way;
		end else if (lru) begin
			way_sel = old_way;
		end else begin
			way_sel = lcg_q[WAY_BITS-1:0];
		end
		// filling an invalid way ages every valid line
		old_age = (hit || evict) ? cur_row[way_sel].age : WAY_BITS'(NUM_WAYS - 1);
	end

	always_comb begin
		new_row = cur_row;
		if (!hit) begin
			new_row[way_sel].tag = req_q.line_tag;
			new_row[way_sel].valid = 1'b1;
			new_row[way_sel].dirty = 1'b0;
		end
		if (lru) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if ((WAY_BITS'(w) != way_sel) && cur_row[w].valid
						&& (cur_row[w].age < old_age)) begin
					new_row[w].age = cur_row[w].age + WAY_BITS'(1);
				end
			end
			new_row[way_sel].age = '0;
		end
		if (req_q.mode == MODE_DWRITE) begin
			new_row[way_sel].dirty = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
			row_q <= mem[in_row];
		end
		if (cmd.commit) begin
			mem[cur_idx] <= new_row;
			rsp_q.hit <= hit;
			rsp_q.way <= way_sel;
			rsp_q.victim_valid <= evict;
			rsp_q.victim_dirty <= evict && cur_row[way_sel].dirty;
			rsp_q.victim_tag <= evict ? cur_row[way_sel].tag : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			init_rd_q <= 1'b0;
			repl_mode_q <= REPL_LRU;
			lcg_q <= SEED_RESET;
		end else begin
			if (cmd.accept) init_rd_q <= row_init_q[in_row];
			if (cmd.commit) row_init_q[cur_idx] <= 1'b1;
			if (cfg_we && (cfg_index == CFG_REPL_MODE)) begin
				repl_mode_q <= cfg_data[0];
			end
			if (cfg_we && (cfg_index == CFG_SEED)) begin
				lcg_q <= cfg_data;
			end else if (cmd.commit && rand_take) begin
				lcg_q <= lcg_next;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/set_assoc_cache_directory.sv @@
// the request and the set's row are registered at accept, and the result at commit;
// a new item is taken only after the last commits, set by the read-modify-write of
// the set's row in the directory memory (read at accept, update and write at commit)
// a stalled result holds the directory update until the result register frees
// reset: all lines invalid, clean and age zero at once through per-row flags,
// no clearing pass; replacement is lru and the generator state is 1
module set_assoc_cache_directory import sacd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cmd_t cmd;

	sacd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd(cmd)
	);

	sacd_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rsp(rsp)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> req_stall)
		else $error("accepted item did not hold off the next one");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("committed item did not present a result");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in the same cycle");

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.hit) |-> !rsp.victim_valid && !rsp.victim_dirty)
		else $error("hit reported a victim");
`endif

endmodule
